// ===== hdl/mhit_pkg.sv =====
`timescale 1ns / 1ps

package mhit_pkg;

    // Coordinate format: signed fixed point, Q23.8 by default.
    localparam int COORD_BITS = 32;
    localparam int FRAC_BITS  = 8;

    // Widths of the exact side-of-line arithmetic.
    localparam int DELTA_BITS = COORD_BITS + 1;
    localparam int PROD_BITS  = 2 * DELTA_BITS;
    localparam int DIFF_BITS  = PROD_BITS + 1;

    // Field widths fixed by the interface.
    localparam int TAG_BITS      = 32;
    localparam int OPCODE_BITS   = 2;
    localparam int CFG_IDX_BITS  = 3;
    localparam int CFG_DATA_BITS = 32;

    // Job queue between the front and the back.
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_BITS   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

    // One selection rectangle corner is tested per step.
    localparam int CORNER_BITS = 2;

    typedef logic signed [COORD_BITS-1:0] coord_t;

    // Input opcodes.
    localparam logic [OPCODE_BITS-1:0] OP_BOX   = 2'd0;
    localparam logic [OPCODE_BITS-1:0] OP_SEG   = 2'd1;
    localparam logic [OPCODE_BITS-1:0] OP_POINT = 2'd2;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_CORNER_AX = 3'd0,
        CFG_CORNER_AY = 3'd1,
        CFG_CORNER_BX = 3'd2,
        CFG_CORNER_BY = 3'd3,
        CFG_CROSSING  = 3'd4
    } cfg_index_t;

    typedef struct packed {
        logic [OPCODE_BITS-1:0] opcode;
        logic [TAG_BITS-1:0]    entity_tag;
        coord_t                 coord_ax;
        coord_t                 coord_ay;
        coord_t                 coord_bx;
        coord_t                 coord_by;
        logic                   last_point;
    } in_word_t;

    typedef struct packed {
        logic [TAG_BITS-1:0] result_tag;
        logic                hit;
    } out_word_t;

    // Ordered selection rectangle and mode.
    typedef struct packed {
        coord_t x0;
        coord_t y0;
        coord_t x1;
        coord_t y1;
        logic   crossing;
    } sel_t;

    // What the back has to do with a job.
    typedef enum logic [1:0] {
        JOB_BOX_INSIDE,
        JOB_BOX_OVERLAP,
        JOB_SEG,
        JOB_POINT
    } job_kind_t;

    typedef struct packed {
        job_kind_t           kind;
        logic [TAG_BITS-1:0] tag;
        coord_t              ax;
        coord_t              ay;
        coord_t              bx;
        coord_t              by;
        logic                last;
    } job_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MUL,
        ST_SUB,
        ST_RES
    } back_state_t;

endpackage

// ===== hdl/marquee_hit_test_top.sv =====
`timescale 1ns / 1ps

// Marquee selection hit test against a rectangle held in configuration.
// Input channel: item_valid / item_stall carry one word per shape op (box,
// segment, or polyline point with a last mark). Result channel:
// result_valid / result_stall carry the tag and hit flag; box and segment
// ops give one word each, a polyline gives one word at its last point.
// Configuration: cfg_wr_en with cfg_index and cfg_data writes one register
// per cycle; write only while no word is in flight.
// Boxes, window segments and the first point of a polyline go from the
// queue straight to the result step; crossing segments and later polyline
// points first run the crossing test. The back finishes one op before it
// takes the next; the crossing test steps through the four rectangle
// corners on a single pair of 33 x 33 multipliers, one corner per cycle,
// and then does the last exact subtract.
// A two-entry job queue decouples input from the back; item_stall rises
// only when it is full. When result_stall is held, the result word waits
// in the output register, the back holds its next answer, and the queue
// fills before the input stalls.
// Reset clears the configuration to zero, empties the queue and clears
// the polyline state; no clearing pass is needed.
module marquee_hit_test_top (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                item_valid,
    output logic                                item_stall,
    input  mhit_pkg::in_word_t                  item,
    output logic                                result_valid,
    input  logic                                result_stall,
    output mhit_pkg::out_word_t                 result,
    input  logic                                cfg_wr_en,
    input  logic [mhit_pkg::CFG_IDX_BITS-1:0]   cfg_index,
    input  logic [mhit_pkg::CFG_DATA_BITS-1:0]  cfg_data
);

    mhit_pkg::sel_t sel;
    mhit_pkg::job_t push_job;
    mhit_pkg::job_t head;
    logic           push;
    logic           pop;
    logic           queue_empty;
    logic           queue_full;

    // Configuration registers and ordered rectangle.
    mhit_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .sel       (sel)
    );

    // Accept and classify input words.
    mhit_front u_front (
        .item_valid (item_valid),
        .item_stall (item_stall),
        .item       (item),
        .crossing   (sel.crossing),
        .queue_full (queue_full),
        .push       (push),
        .job        (push_job)
    );

    // Job queue between front and back.
    mhit_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .head     (head),
        .empty    (queue_empty),
        .full     (queue_full)
    );

    // Tests, polyline state and result register.
    mhit_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .sel          (sel),
        .queue_empty  (queue_empty),
        .head         (head),
        .pop          (pop),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

endmodule

// ===== hdl/mhit_cfg.sv =====
`timescale 1ns / 1ps

module mhit_cfg (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_wr_en,
    input  logic [mhit_pkg::CFG_IDX_BITS-1:0]    cfg_index,
    input  logic [mhit_pkg::CFG_DATA_BITS-1:0]   cfg_data,
    output mhit_pkg::sel_t                       sel
);

    mhit_pkg::coord_t corner_ax_reg;
    mhit_pkg::coord_t corner_ay_reg;
    mhit_pkg::coord_t corner_bx_reg;
    mhit_pkg::coord_t corner_by_reg;
    logic             crossing_reg;

    // Register writes; an index beyond the list is ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            corner_ax_reg <= '0;
            corner_ay_reg <= '0;
            corner_bx_reg <= '0;
            corner_by_reg <= '0;
            crossing_reg  <= 1'b0;
        end
        else if (cfg_wr_en)
        begin
            unique case (mhit_pkg::cfg_index_t'(cfg_index))
                mhit_pkg::CFG_CORNER_AX:
                    corner_ax_reg <= mhit_pkg::coord_t'(cfg_data[mhit_pkg::COORD_BITS-1:0]);
                mhit_pkg::CFG_CORNER_AY:
                    corner_ay_reg <= mhit_pkg::coord_t'(cfg_data[mhit_pkg::COORD_BITS-1:0]);
                mhit_pkg::CFG_CORNER_BX:
                    corner_bx_reg <= mhit_pkg::coord_t'(cfg_data[mhit_pkg::COORD_BITS-1:0]);
                mhit_pkg::CFG_CORNER_BY:
                    corner_by_reg <= mhit_pkg::coord_t'(cfg_data[mhit_pkg::COORD_BITS-1:0]);
                mhit_pkg::CFG_CROSSING:
                    crossing_reg  <= cfg_data[0];
                default:
                    crossing_reg  <= crossing_reg;
            endcase
        end
    end

    // Order the corners into min and max per axis.
    always_comb
    begin
        sel.x0       = (corner_ax_reg < corner_bx_reg) ? corner_ax_reg : corner_bx_reg;
        sel.x1       = (corner_ax_reg > corner_bx_reg) ? corner_ax_reg : corner_bx_reg;
        sel.y0       = (corner_ay_reg < corner_by_reg) ? corner_ay_reg : corner_by_reg;
        sel.y1       = (corner_ay_reg > corner_by_reg) ? corner_ay_reg : corner_by_reg;
        sel.crossing = crossing_reg;
    end

endmodule

// ===== hdl/mhit_front.sv =====
`timescale 1ns / 1ps

module mhit_front (
    input  logic                item_valid,
    output logic                item_stall,
    input  mhit_pkg::in_word_t  item,
    input  logic                crossing,
    input  logic                queue_full,
    output logic                push,
    output mhit_pkg::job_t      job
);

    logic accept;

    // A word is taken whenever the queue has room.
    assign item_stall = queue_full;
    assign accept     = item_valid && !queue_full;

    // Classify the word into a job for the back.
    always_comb
    begin
        job.tag  = item.entity_tag;
        job.ax   = item.coord_ax;
        job.ay   = item.coord_ay;
        job.bx   = item.coord_bx;
        job.by   = item.coord_by;
        job.last = item.last_point;
        job.kind = mhit_pkg::JOB_BOX_INSIDE;
        push     = accept;
        unique case (item.opcode)
            mhit_pkg::OP_BOX:
            begin
                job.kind = crossing ? mhit_pkg::JOB_BOX_OVERLAP : mhit_pkg::JOB_BOX_INSIDE;
            end
            mhit_pkg::OP_SEG:
            begin
                if (crossing)
                begin
                    job.kind = mhit_pkg::JOB_SEG;
                end
                else
                begin
                    // Window mode tests the endpoints' box.
                    job.kind = mhit_pkg::JOB_BOX_INSIDE;
                    job.ax   = (item.coord_ax < item.coord_bx) ? item.coord_ax : item.coord_bx;
                    job.bx   = (item.coord_ax > item.coord_bx) ? item.coord_ax : item.coord_bx;
                    job.ay   = (item.coord_ay < item.coord_by) ? item.coord_ay : item.coord_by;
                    job.by   = (item.coord_ay > item.coord_by) ? item.coord_ay : item.coord_by;
                end
            end
            mhit_pkg::OP_POINT:
            begin
                job.kind = mhit_pkg::JOB_POINT;
            end
            default:
            begin
                // The unused opcode is taken and dropped.
                push = 1'b0;
            end
        endcase
    end

endmodule

// ===== hdl/mhit_queue.sv =====
`timescale 1ns / 1ps

module mhit_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  mhit_pkg::job_t  push_job,
    input  logic            pop,
    output mhit_pkg::job_t  head,
    output logic            empty,
    output logic            full
);

    mhit_pkg::job_t                   entry_reg [mhit_pkg::QUEUE_DEPTH];
    logic [mhit_pkg::QPTR_BITS-1:0]   wr_ptr_reg;
    logic [mhit_pkg::QPTR_BITS-1:0]   rd_ptr_reg;
    logic [mhit_pkg::QCNT_BITS-1:0]   count_reg;
    logic                             do_push;
    logic                             do_pop;

    assign empty   = (count_reg == '0);
    assign full    = (count_reg == mhit_pkg::QCNT_BITS'(mhit_pkg::QUEUE_DEPTH));
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign head    = entry_reg[rd_ptr_reg];

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_job;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == mhit_pkg::QPTR_BITS'(mhit_pkg::QUEUE_DEPTH - 1))
                              ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == mhit_pkg::QPTR_BITS'(mhit_pkg::QUEUE_DEPTH - 1))
                              ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    // The count never runs past the depth.
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= mhit_pkg::QCNT_BITS'(mhit_pkg::QUEUE_DEPTH))
        else $error("job queue count beyond depth");

endmodule

// ===== hdl/mhit_back.sv =====
`timescale 1ns / 1ps

module mhit_back (
    input  logic                clk,
    input  logic                rst_n,
    input  mhit_pkg::sel_t      sel,
    input  logic                queue_empty,
    input  mhit_pkg::job_t      head,
    output logic                pop,
    output logic                result_valid,
    input  logic                result_stall,
    output mhit_pkg::out_word_t result
);

    localparam logic [1:0] SEEN_NONE = 2'd0;
    localparam logic [1:0] SEEN_ONE  = 2'd1;
    localparam logic [1:0] SEEN_TWO  = 2'd2;
    localparam logic [mhit_pkg::CORNER_BITS-1:0] LAST_CORNER = '1;

    typedef logic signed [mhit_pkg::DELTA_BITS-1:0] delta_t;
    typedef logic signed [mhit_pkg::PROD_BITS-1:0]  prod_t;
    typedef logic signed [mhit_pkg::DIFF_BITS-1:0]  diff_t;

    // Closed containment of a box in the selection rectangle.
    function automatic logic box_inside(
        input mhit_pkg::coord_t ax,
        input mhit_pkg::coord_t ay,
        input mhit_pkg::coord_t bx,
        input mhit_pkg::coord_t by,
        input mhit_pkg::sel_t   s
    );
        return (ax >= s.x0) && (bx <= s.x1) && (ay >= s.y0) && (by <= s.y1);
    endfunction

    // Closed overlap of a box with the selection rectangle.
    function automatic logic box_overlap(
        input mhit_pkg::coord_t ax,
        input mhit_pkg::coord_t ay,
        input mhit_pkg::coord_t bx,
        input mhit_pkg::coord_t by,
        input mhit_pkg::sel_t   s
    );
        return !((bx < s.x0) || (ax > s.x1) || (by < s.y0) || (ay > s.y1));
    endfunction

    // Overlap of a segment's bounding box, without ordering the endpoints.
    function automatic logic seg_box_overlap(
        input mhit_pkg::coord_t x0,
        input mhit_pkg::coord_t y0,
        input mhit_pkg::coord_t x1,
        input mhit_pkg::coord_t y1,
        input mhit_pkg::sel_t   s
    );
        return !(((x0 < s.x0) && (x1 < s.x0)) || ((x0 > s.x1) && (x1 > s.x1)) ||
                 ((y0 < s.y0) && (y1 < s.y0)) || ((y0 > s.y1) && (y1 > s.y1)));
    endfunction

    mhit_pkg::back_state_t state_reg;
    mhit_pkg::back_state_t state_next;

    mhit_pkg::job_t   job_reg;
    mhit_pkg::coord_t x0_reg;
    mhit_pkg::coord_t y0_reg;
    mhit_pkg::coord_t x1_reg;
    mhit_pkg::coord_t y1_reg;
    logic [mhit_pkg::CORNER_BITS-1:0] corner_reg;
    prod_t            prod_a_reg;
    prod_t            prod_b_reg;
    logic             all_pos_reg;
    logic             all_neg_reg;

    mhit_pkg::coord_t prev_x_reg;
    mhit_pkg::coord_t prev_y_reg;
    logic [1:0]       seen_reg;
    mhit_pkg::coord_t bmin_x_reg;
    mhit_pkg::coord_t bmin_y_reg;
    mhit_pkg::coord_t bmax_x_reg;
    mhit_pkg::coord_t bmax_y_reg;
    logic             cross_reg;

    logic [1:0]       seen_next;
    mhit_pkg::coord_t bmin_x_next;
    mhit_pkg::coord_t bmin_y_next;
    mhit_pkg::coord_t bmax_x_next;
    mhit_pkg::coord_t bmax_y_next;
    logic             cross_next;

    logic                 out_valid_reg;
    mhit_pkg::out_word_t  out_reg;

    logic             head_needs_seg;
    logic             has_result;
    logic             out_free;
    logic             res_fire;
    logic             mul_en;
    logic             acc_en;

    mhit_pkg::coord_t corner_x;
    mhit_pkg::coord_t corner_y;
    delta_t           dx;
    delta_t           dy;
    delta_t           dcx;
    delta_t           dcy;
    prod_t            prod_a;
    prod_t            prod_b;
    diff_t            diff;
    logic             diff_neg;
    logic             diff_zero;
    logic             seg_hit;
    logic             hit;

    assign head_needs_seg = (head.kind == mhit_pkg::JOB_SEG) ||
                            ((head.kind == mhit_pkg::JOB_POINT) && (seen_reg != SEEN_NONE));
    assign has_result     = (job_reg.kind != mhit_pkg::JOB_POINT) || job_reg.last;
    assign out_free       = !out_valid_reg || !result_stall;

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            mhit_pkg::ST_IDLE:
            begin
                if (!queue_empty)
                begin
                    state_next = head_needs_seg ? mhit_pkg::ST_MUL : mhit_pkg::ST_RES;
                end
            end
            mhit_pkg::ST_MUL:
            begin
                if (corner_reg == LAST_CORNER)
                begin
                    state_next = mhit_pkg::ST_SUB;
                end
            end
            mhit_pkg::ST_SUB:
            begin
                state_next = mhit_pkg::ST_RES;
            end
            mhit_pkg::ST_RES:
            begin
                if (!has_result || out_free)
                begin
                    state_next = mhit_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = mhit_pkg::ST_IDLE;
            end
        endcase
    end

    // Control outputs of the sequencer.
    always_comb
    begin
        pop      = 1'b0;
        mul_en   = 1'b0;
        acc_en   = 1'b0;
        res_fire = 1'b0;
        unique case (state_reg)
            mhit_pkg::ST_IDLE:
            begin
                pop = !queue_empty;
            end
            mhit_pkg::ST_MUL:
            begin
                mul_en = 1'b1;
                acc_en = (corner_reg != '0);
            end
            mhit_pkg::ST_SUB:
            begin
                acc_en = 1'b1;
            end
            mhit_pkg::ST_RES:
            begin
                res_fire = !has_result || out_free;
            end
            default:
            begin
                pop = 1'b0;
            end
        endcase
    end

    // One corner per step: two exact products of the side-of-line test.
    always_comb
    begin
        corner_x  = corner_reg[0] ? sel.x1 : sel.x0;
        corner_y  = corner_reg[1] ? sel.y1 : sel.y0;
        dx        = {x1_reg[mhit_pkg::COORD_BITS-1], x1_reg} -
                    {x0_reg[mhit_pkg::COORD_BITS-1], x0_reg};
        dy        = {y1_reg[mhit_pkg::COORD_BITS-1], y1_reg} -
                    {y0_reg[mhit_pkg::COORD_BITS-1], y0_reg};
        dcx       = {corner_x[mhit_pkg::COORD_BITS-1], corner_x} -
                    {x0_reg[mhit_pkg::COORD_BITS-1], x0_reg};
        dcy       = {corner_y[mhit_pkg::COORD_BITS-1], corner_y} -
                    {y0_reg[mhit_pkg::COORD_BITS-1], y0_reg};
        prod_a    = dx * dcy;
        prod_b    = dy * dcx;
        diff      = {prod_a_reg[mhit_pkg::PROD_BITS-1], prod_a_reg} -
                    {prod_b_reg[mhit_pkg::PROD_BITS-1], prod_b_reg};
        diff_neg  = diff[mhit_pkg::DIFF_BITS-1];
        diff_zero = (diff == '0);
    end

    // Polyline update and the answer for the current job.
    always_comb
    begin
        seg_hit = seg_box_overlap(x0_reg, y0_reg, x1_reg, y1_reg, sel) &&
                  !all_pos_reg && !all_neg_reg;

        if (seen_reg == SEEN_NONE)
        begin
            bmin_x_next = x1_reg;
            bmax_x_next = x1_reg;
            bmin_y_next = y1_reg;
            bmax_y_next = y1_reg;
            cross_next  = 1'b0;
            seen_next   = SEEN_ONE;
        end
        else
        begin
            bmin_x_next = (x1_reg < bmin_x_reg) ? x1_reg : bmin_x_reg;
            bmax_x_next = (x1_reg > bmax_x_reg) ? x1_reg : bmax_x_reg;
            bmin_y_next = (y1_reg < bmin_y_reg) ? y1_reg : bmin_y_reg;
            bmax_y_next = (y1_reg > bmax_y_reg) ? y1_reg : bmax_y_reg;
            cross_next  = cross_reg || seg_hit;
            seen_next   = SEEN_TWO;
        end

        unique case (job_reg.kind)
            mhit_pkg::JOB_BOX_INSIDE:
                hit = box_inside(job_reg.ax, job_reg.ay, job_reg.bx, job_reg.by, sel);
            mhit_pkg::JOB_BOX_OVERLAP:
                hit = box_overlap(job_reg.ax, job_reg.ay, job_reg.bx, job_reg.by, sel);
            mhit_pkg::JOB_SEG:
                hit = seg_hit;
            mhit_pkg::JOB_POINT:
            begin
                if (seen_next != SEEN_TWO)
                begin
                    hit = 1'b0;
                end
                else if (sel.crossing)
                begin
                    hit = cross_next;
                end
                else
                begin
                    hit = box_inside(bmin_x_next, bmin_y_next, bmax_x_next, bmax_y_next, sel);
                end
            end
            default:
                hit = 1'b0;
        endcase
    end

    // Job and arithmetic registers.
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            job_reg <= head;
            if (head.kind == mhit_pkg::JOB_POINT)
            begin
                x0_reg <= prev_x_reg;
                y0_reg <= prev_y_reg;
                x1_reg <= head.ax;
                y1_reg <= head.ay;
            end
            else
            begin
                x0_reg <= head.ax;
                y0_reg <= head.ay;
                x1_reg <= head.bx;
                y1_reg <= head.by;
            end
        end
        if (mul_en)
        begin
            prod_a_reg <= prod_a;
            prod_b_reg <= prod_b;
        end
        if (res_fire && has_result)
        begin
            out_reg.result_tag <= job_reg.tag;
            out_reg.hit        <= hit;
        end
    end

    // Sequencer, corner sign accumulation, polyline state and output flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= mhit_pkg::ST_IDLE;
            corner_reg    <= '0;
            all_pos_reg   <= 1'b1;
            all_neg_reg   <= 1'b1;
            prev_x_reg    <= '0;
            prev_y_reg    <= '0;
            seen_reg      <= SEEN_NONE;
            bmin_x_reg    <= '0;
            bmin_y_reg    <= '0;
            bmax_x_reg    <= '0;
            bmax_y_reg    <= '0;
            cross_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            if (pop)
            begin
                corner_reg  <= '0;
                all_pos_reg <= 1'b1;
                all_neg_reg <= 1'b1;
            end
            else
            begin
                if (mul_en)
                begin
                    corner_reg <= corner_reg + 1'b1;
                end
                if (acc_en)
                begin
                    all_pos_reg <= all_pos_reg && !diff_neg && !diff_zero;
                    all_neg_reg <= all_neg_reg && diff_neg;
                end
            end

            if (res_fire && (job_reg.kind == mhit_pkg::JOB_POINT))
            begin
                prev_x_reg <= x1_reg;
                prev_y_reg <= y1_reg;
                bmin_x_reg <= bmin_x_next;
                bmin_y_reg <= bmin_y_next;
                bmax_x_reg <= bmax_x_next;
                bmax_y_reg <= bmax_y_next;
                if (job_reg.last)
                begin
                    seen_reg  <= SEEN_NONE;
                    cross_reg <= 1'b0;
                end
                else
                begin
                    seen_reg  <= seen_next;
                    cross_reg <= cross_next;
                end
            end

            if (res_fire && has_result)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && !result_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign result_valid = out_valid_reg;
    assign result       = out_reg;

    // Only segment tests run through the multiplier steps.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == mhit_pkg::ST_MUL) |->
            ((job_reg.kind == mhit_pkg::JOB_SEG) || (job_reg.kind == mhit_pkg::JOB_POINT)))
        else $error("multiplier steps entered for a box job");

    // The final subtract follows the last corner product.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == mhit_pkg::ST_SUB) |->
            (($past(state_reg) == mhit_pkg::ST_MUL) && ($past(corner_reg) == LAST_CORNER)))
        else $error("subtract step without four corner products");

    // The point count saturates at two.
    assert property (@(posedge clk) disable iff (!rst_n)
        seen_reg != 2'd3)
        else $error("polyline point count out of range");

    // A pending result is never overwritten while the receiver stalls.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && result_stall) |-> !(res_fire && has_result))
        else $error("result word overwritten under stall");

endmodule

// ===== sim/mhit_checker.sv =====
`timescale 1ns / 1ps

// Watches the shape and result channels of the marquee hit tester, keeps its
// own copy of the selection rectangle and the polyline state, and checks every
// result word against the oldest predicted one.
module mhit_checker (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                item_valid,
    input  logic                                item_stall,
    input  mhit_pkg::in_word_t                  item,
    input  logic                                result_valid,
    input  logic                                result_stall,
    input  mhit_pkg::out_word_t                 result,
    input  logic                                cfg_wr_en,
    input  logic [mhit_pkg::CFG_IDX_BITS-1:0]   cfg_index,
    input  logic [mhit_pkg::CFG_DATA_BITS-1:0]  cfg_data,
    output int                                  mismatches,
    output int                                  hits_owed
);

    // Selection rectangle corners as written, and the mode.
    longint sel_ax;
    longint sel_ay;
    longint sel_bx;
    longint sel_by;
    bit     crossing;

    // Polyline stream state.
    longint last_x;
    longint last_y;
    int     pts;
    longint run_x0;
    longint run_y0;
    longint run_x1;
    longint run_y1;
    bit     run_hit;

    // Result words predicted but not yet seen.
    mhit_pkg::out_word_t pending_hits[$];

    initial mismatches = 0;

    function automatic longint lmin(longint a, longint b);
        return (a < b) ? a : b;
    endfunction

    function automatic longint lmax(longint a, longint b);
        return (a > b) ? a : b;
    endfunction

    // Window test: the box lies within the closed, ordered rectangle.
    function automatic bit inside_sel(longint ax, longint ay, longint bx, longint by);
        return ax >= lmin(sel_ax, sel_bx) && bx <= lmax(sel_ax, sel_bx) &&
               ay >= lmin(sel_ay, sel_by) && by <= lmax(sel_ay, sel_by);
    endfunction

    // Crossing test for boxes: closed overlap, fields taken as given.
    function automatic bit overlaps_sel(longint ax, longint ay, longint bx, longint by);
        return !(bx < lmin(sel_ax, sel_bx) || ax > lmax(sel_ax, sel_bx) ||
                 by < lmin(sel_ay, sel_by) || ay > lmax(sel_ay, sel_by));
    endfunction

    // Sign of the corner (cx, cy) against the line through (x0, y0) along
    // (dx, dy), from exact wide products.
    function automatic int line_side(longint x0, longint y0, longint dx, longint dy,
                                     longint cx, longint cy);
        logic signed [127:0] wdx;
        logic signed [127:0] wdy;
        logic signed [127:0] wex;
        logic signed [127:0] wey;
        logic signed [127:0] area;
        wdx = dx;
        wdy = dy;
        wex = cx - x0;
        wey = cy - y0;
        area = wdx * wey - wdy * wex;
        if (area < 0)
            return -1;
        if (area == 0)
            return 0;
        return 1;
    endfunction

    // Exact segment against closed rectangle: the boxes must overlap and
    // the four corners must not all lie strictly on one side of the line.
    function automatic bit segment_hits(longint x0, longint y0, longint x1, longint y1);
        longint sx0;
        longint sy0;
        longint sx1;
        longint sy1;
        int     s0;
        int     s1;
        int     s2;
        int     s3;
        if (!overlaps_sel(lmin(x0, x1), lmin(y0, y1), lmax(x0, x1), lmax(y0, y1)))
            return 1'b0;
        sx0 = lmin(sel_ax, sel_bx);
        sy0 = lmin(sel_ay, sel_by);
        sx1 = lmax(sel_ax, sel_bx);
        sy1 = lmax(sel_ay, sel_by);
        s0 = line_side(x0, y0, x1 - x0, y1 - y0, sx0, sy0);
        s1 = line_side(x0, y0, x1 - x0, y1 - y0, sx1, sy0);
        s2 = line_side(x0, y0, x1 - x0, y1 - y0, sx0, sy1);
        s3 = line_side(x0, y0, x1 - x0, y1 - y0, sx1, sy1);
        if (s0 > 0 && s1 > 0 && s2 > 0 && s3 > 0)
            return 1'b0;
        if (s0 < 0 && s1 < 0 && s2 < 0 && s3 < 0)
            return 1'b0;
        return 1'b1;
    endfunction

    task automatic report_mismatch(string msg);
        $display("MISMATCH at %0t ns: %s", $time, msg);
        mismatches++;
    endtask

    // Works out the result word, if any, that one accepted shape word causes.
    task automatic judge_shape(mhit_pkg::in_word_t w);
        longint              ax;
        longint              ay;
        longint              bx;
        longint              by;
        mhit_pkg::out_word_t exp_word;
        bit                  answers;
        ax = longint'(signed'(w.coord_ax));
        ay = longint'(signed'(w.coord_ay));
        bx = longint'(signed'(w.coord_bx));
        by = longint'(signed'(w.coord_by));
        answers = 1'b1;
        exp_word.result_tag = w.entity_tag;
        exp_word.hit = 1'b0;
        case (w.opcode)
            mhit_pkg::OP_BOX:
            begin
                exp_word.hit = crossing ? overlaps_sel(ax, ay, bx, by)
                                        : inside_sel(ax, ay, bx, by);
            end
            mhit_pkg::OP_SEG:
            begin
                exp_word.hit = crossing ? segment_hits(ax, ay, bx, by)
                                        : inside_sel(lmin(ax, bx), lmin(ay, by),
                                                     lmax(ax, bx), lmax(ay, by));
            end
            mhit_pkg::OP_POINT:
            begin
                if (pts == 0)
                begin
                    run_x0 = ax;
                    run_x1 = ax;
                    run_y0 = ay;
                    run_y1 = ay;
                    run_hit = 1'b0;
                    pts = 1;
                end
                else
                begin
                    run_x0 = lmin(run_x0, ax);
                    run_y0 = lmin(run_y0, ay);
                    run_x1 = lmax(run_x1, ax);
                    run_y1 = lmax(run_y1, ay);
                    if (segment_hits(last_x, last_y, ax, ay))
                        run_hit = 1'b1;
                    pts = 2;
                end
                last_x = ax;
                last_y = ay;
                answers = w.last_point;
                if (w.last_point)
                begin
                    if (pts < 2)
                        exp_word.hit = 1'b0;
                    else if (crossing)
                        exp_word.hit = run_hit;
                    else
                        exp_word.hit = inside_sel(run_x0, run_y0, run_x1, run_y1);
                    pts = 0;
                    run_hit = 1'b0;
                end
            end
            default:
            begin
                answers = 1'b0;
            end
        endcase
        if (answers)
            pending_hits = {pending_hits, exp_word};
    endtask

    // Compares one accepted result word with the oldest prediction.
    task automatic compare_word(mhit_pkg::out_word_t got);
        mhit_pkg::out_word_t exp_word;
        if (pending_hits.size() == 0)
        begin
            report_mismatch($sformatf("unexpected result word, tag %h hit %0b",
                                      got.result_tag, got.hit));
            return;
        end
        exp_word = pending_hits.pop_front();
        if (got.result_tag !== exp_word.result_tag)
            report_mismatch($sformatf("result_tag %h, expected %h",
                                      got.result_tag, exp_word.result_tag));
        if (got.hit !== exp_word.hit)
            report_mismatch($sformatf("hit %b for tag %h, expected %b",
                                      got.hit, exp_word.result_tag, exp_word.hit));
    endtask

    // Results are checked before the shape of the same edge is predicted.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sel_ax = 0;
            sel_ay = 0;
            sel_bx = 0;
            sel_by = 0;
            crossing = 1'b0;
            last_x = 0;
            last_y = 0;
            pts = 0;
            run_x0 = 0;
            run_y0 = 0;
            run_x1 = 0;
            run_y1 = 0;
            run_hit = 1'b0;
            pending_hits.delete();
            hits_owed <= 0;
        end
        else
        begin
            if (result_valid && !result_stall)
                compare_word(result);
            if (item_valid && !item_stall)
                judge_shape(item);
            if (cfg_wr_en)
            begin
                case (cfg_index)
                    mhit_pkg::CFG_CORNER_AX: sel_ax = longint'(signed'(cfg_data));
                    mhit_pkg::CFG_CORNER_AY: sel_ay = longint'(signed'(cfg_data));
                    mhit_pkg::CFG_CORNER_BX: sel_bx = longint'(signed'(cfg_data));
                    mhit_pkg::CFG_CORNER_BY: sel_by = longint'(signed'(cfg_data));
                    mhit_pkg::CFG_CROSSING:  crossing = cfg_data[0];
                    default:                 ;
                endcase
            end
            hits_owed <= pending_hits.size();
        end
    end

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps

// Drives shape words and selection settings into the marquee hit tester,
// stalls the result side at random, and gives the verdict.
module tb_top;

    // Opcode that the block has to ignore.
    localparam logic [mhit_pkg::OPCODE_BITS-1:0] OP_UNUSED = 2'd3;

    localparam mhit_pkg::coord_t C_MIN = mhit_pkg::coord_t'(32'h8000_0000);
    localparam mhit_pkg::coord_t C_MAX = mhit_pkg::coord_t'(32'h7fff_ffff);
    localparam longint COORD_LO = -(longint'(1) << 31);
    localparam longint COORD_HI = (longint'(1) << 31) - 1;

    logic                               clk;
    logic                               rst_n;
    logic                               item_valid;
    logic                               item_stall;
    mhit_pkg::in_word_t                 item;
    logic                               result_valid;
    logic                               result_stall;
    mhit_pkg::out_word_t                result;
    logic                               cfg_wr_en;
    logic [mhit_pkg::CFG_IDX_BITS-1:0]  cfg_index;
    logic [mhit_pkg::CFG_DATA_BITS-1:0] cfg_data;

    int mismatches;
    int hits_owed;

    // Shapes sent so far, ignored opcodes not counted.
    int sent = 0;
    // When set, neither side idles.
    bit calm = 1'b0;
    int calm_at = 0;

    // Ordered bounds of the current rectangle, for aiming the stimulus.
    longint lo_x = 0;
    longint hi_x = 0;
    longint lo_y = 0;
    longint hi_y = 0;

    marquee_hit_test_top dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    mhit_checker hit_check (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .mismatches   (mismatches),
        .hits_owed    (hits_owed)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Run limit.
    initial
    begin
        #5_000_000;
        $display("[marquee_hit_test_top] ERROR");
        $finish;
    end

    // Result side: stall bursts, mostly short and now and then long.
    initial
    begin
        int hold;
        bit stalling;
        result_stall = 1'b0;
        hold = 0;
        stalling = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold == 0)
            begin
                if (calm || stalling)
                begin
                    stalling = 1'b0;
                    hold = $urandom_range(1, 8);
                end
                else
                begin
                    stalling = 1'b1;
                    hold = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                       : $urandom_range(1, 3);
                end
            end
            hold--;
            result_stall <= stalling && !calm;
        end
    end

    // Input gap length: mostly none or short, a few long.
    function automatic int pick_gap();
        int r;
        if (calm)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // Coordinate aimed around [lo, hi]: edges, one past the edges, the
    // area nearby, or anything at all. Tight picks stay inside.
    function automatic mhit_pkg::coord_t pick_coord(longint lo, longint hi, bit tight);
        longint span;
        longint v;
        int     r;
        r = $urandom_range(0, 99);
        span = hi - lo + 64;
        if (r < 12 && !tight)
            return mhit_pkg::coord_t'($urandom);
        if (r < 20)
            v = lo;
        else if (r < 28)
            v = hi;
        else if (tight)
            v = lo + longint'({$urandom, $urandom} % (hi - lo + 1));
        else if (r < 32)
            v = lo - 1;
        else if (r < 36)
            v = hi + 1;
        else
            v = lo - span / 2 + longint'({$urandom, $urandom} % (2 * span));
        if (v < COORD_LO)
            v = COORD_LO;
        if (v > COORD_HI)
            v = COORD_HI;
        return mhit_pkg::coord_t'(v);
    endfunction

    // Offers one word and waits until it is taken.
    task automatic send_item(logic [mhit_pkg::OPCODE_BITS-1:0] op,
                             logic [mhit_pkg::TAG_BITS-1:0] tag,
                             mhit_pkg::coord_t ax, mhit_pkg::coord_t ay,
                             mhit_pkg::coord_t bx, mhit_pkg::coord_t by,
                             logic last);
        int                 gap;
        mhit_pkg::in_word_t w;
        w.opcode = op;
        w.entity_tag = tag;
        w.coord_ax = ax;
        w.coord_ay = ay;
        w.coord_bx = bx;
        w.coord_by = by;
        w.last_point = last;
        gap = pick_gap();
        @(negedge clk);
        if (gap > 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        item_valid <= 1'b1;
        item <= w;
        do
            @(posedge clk);
        while (item_stall);
        if (op != OP_UNUSED)
            sent++;
    endtask

    // Drops valid, lets every predicted word arrive, then allows for work
    // still in flight on words that answer nothing.
    task automatic settle();
        @(negedge clk);
        item_valid <= 1'b0;
        while (hits_owed != 0)
            @(posedge clk);
        repeat (30) @(posedge clk);
    endtask

    // Writes all five registers on back-to-back cycles.
    task automatic load_selection(mhit_pkg::coord_t ax, mhit_pkg::coord_t ay,
                                  mhit_pkg::coord_t bx, mhit_pkg::coord_t by,
                                  logic mode);
        mhit_pkg::cfg_index_t               regs[5];
        logic [mhit_pkg::CFG_DATA_BITS-1:0] vals[5];
        regs = '{mhit_pkg::CFG_CORNER_AX, mhit_pkg::CFG_CORNER_AY,
                 mhit_pkg::CFG_CORNER_BX, mhit_pkg::CFG_CORNER_BY,
                 mhit_pkg::CFG_CROSSING};
        vals = '{ax, ay, bx, by, {{(mhit_pkg::CFG_DATA_BITS-1){1'b0}}, mode}};
        for (int i = 0; i < 5; i++)
        begin
            @(negedge clk);
            cfg_wr_en <= 1'b1;
            cfg_index <= regs[i];
            cfg_data <= vals[i];
        end
        @(negedge clk);
        cfg_wr_en <= 1'b0;
        lo_x = (ax < bx) ? ax : bx;
        hi_x = (ax < bx) ? bx : ax;
        lo_y = (ay < by) ? ay : by;
        hi_y = (ay < by) ? by : ay;
    endtask

    // A box or segment word with random content.
    task automatic send_flat(logic [mhit_pkg::OPCODE_BITS-1:0] op, bit tight);
        mhit_pkg::coord_t ax;
        mhit_pkg::coord_t ay;
        mhit_pkg::coord_t bx;
        mhit_pkg::coord_t by;
        mhit_pkg::coord_t t;
        ax = pick_coord(lo_x, hi_x, tight);
        bx = pick_coord(lo_x, hi_x, tight);
        ay = pick_coord(lo_y, hi_y, tight);
        by = pick_coord(lo_y, hi_y, tight);
        // Boxes mostly come ordered; some stay inverted.
        if (op == mhit_pkg::OP_BOX && $urandom_range(0, 3) != 0)
        begin
            if (ax > bx)
            begin
                t = ax;
                ax = bx;
                bx = t;
            end
            if (ay > by)
            begin
                t = ay;
                ay = by;
                by = t;
            end
        end
        send_item(op, $urandom, ax, ay, bx, by, $urandom_range(0, 1));
    endtask

    // One random shape: a box, a segment, a polyline stream that may be
    // broken up by other words, or a word to be ignored.
    task automatic send_shape();
        int r;
        int n;
        int k;
        bit tight;
        r = $urandom_range(0, 99);
        tight = ($urandom_range(0, 2) == 0);
        if (r < 25)
            send_flat(mhit_pkg::OP_BOX, tight);
        else if (r < 50)
            send_flat(mhit_pkg::OP_SEG, tight);
        else if (r < 94)
        begin
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 12) : $urandom_range(1, 6);
            for (int i = 0; i < n; i++)
            begin
                if (i > 0 && $urandom_range(0, 11) == 0)
                begin
                    k = $urandom_range(0, 2);
                    if (k == 0)
                        send_flat(mhit_pkg::OP_BOX, tight);
                    else if (k == 1)
                        send_flat(mhit_pkg::OP_SEG, tight);
                    else
                        send_item(OP_UNUSED, $urandom, $urandom, $urandom, $urandom,
                                  $urandom, $urandom_range(0, 1));
                end
                send_item(mhit_pkg::OP_POINT, $urandom, pick_coord(lo_x, hi_x, tight),
                          pick_coord(lo_y, hi_y, tight), $urandom, $urandom,
                          i == n - 1);
            end
        end
        else
            send_item(OP_UNUSED, $urandom, $urandom, $urandom, $urandom, $urandom,
                      $urandom_range(0, 1));
    endtask

    // Loads one setting and sends random shapes under it.
    task automatic run_phase(mhit_pkg::coord_t ax, mhit_pkg::coord_t ay,
                             mhit_pkg::coord_t bx, mhit_pkg::coord_t by,
                             logic mode, int count);
        int target;
        settle();
        load_selection(ax, ay, bx, by, mode);
        target = sent + count;
        while (sent < target)
        begin
            if (sent >= calm_at)
            begin
                calm = ($urandom_range(0, 2) == 0);
                calm_at = sent + 50;
            end
            send_shape();
        end
    endtask

    function automatic mhit_pkg::coord_t near_origin();
        return mhit_pkg::coord_t'(int'($urandom_range(0, 8000)) - 4000);
    endfunction

    // Main sequence.
    initial
    begin
        mhit_pkg::coord_t cx;
        rst_n = 1'b0;
        item_valid = 1'b0;
        item = '0;
        cfg_wr_en = 1'b0;
        cfg_index = mhit_pkg::CFG_CORNER_AX;
        cfg_data = '0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Reset settings: a point-sized rectangle at the origin, window mode.
        while (sent < 40)
            send_shape();

        // Directed shapes, x corners given in reverse order, crossing mode.
        settle();
        load_selection(1000, -500, -1000, 500, 1'b1);
        send_item(mhit_pkg::OP_BOX, 32'h0, -1000, -500, 1000, 500, 1'b0);
        send_item(mhit_pkg::OP_BOX, 32'hffff_ffff, C_MIN, C_MIN, C_MAX, C_MAX, 1'b1);
        send_item(mhit_pkg::OP_BOX, 3, 500, 200, -500, -200, 1'b0);
        send_item(mhit_pkg::OP_BOX, 4, 1000, -100, 2000, 100, 1'b0);
        send_item(mhit_pkg::OP_BOX, 5, 1001, -100, 2000, 100, 1'b0);
        send_item(mhit_pkg::OP_SEG, 6, -3000, -3000, 3000, 3000, 1'b0);
        // Boxes overlap but the line passes beside the corner.
        send_item(mhit_pkg::OP_SEG, 7, 900, 700, 1200, 400, 1'b0);
        // Line grazes the corner exactly.
        send_item(mhit_pkg::OP_SEG, 8, 900, 600, 1100, 400, 1'b0);
        // Zero-length segments on the edge and just outside.
        send_item(mhit_pkg::OP_SEG, 9, 1000, 0, 1000, 0, 1'b0);
        send_item(mhit_pkg::OP_SEG, 10, 1001, 0, 1001, 0, 1'b1);
        send_item(mhit_pkg::OP_SEG, 11, C_MIN, C_MAX, C_MAX, C_MIN, 1'b0);
        // A polyline of one point answers no hit.
        send_item(mhit_pkg::OP_POINT, 12, 5, 5, 0, 0, 1'b1);
        // A polyline that misses, broken by a box and an ignored word.
        send_item(mhit_pkg::OP_POINT, 13, -2000, 0, 0, 0, 1'b0);
        send_item(mhit_pkg::OP_BOX, 14, -10, -10, 10, 10, 1'b1);
        send_item(mhit_pkg::OP_POINT, 15, 0, 2000, 0, 0, 1'b0);
        send_item(OP_UNUSED, 16, 0, 0, 0, 0, 1'b1);
        send_item(mhit_pkg::OP_POINT, 17, 2000, 0, 0, 0, 1'b1);
        send_item(mhit_pkg::OP_POINT, 18, -10, -10, 0, 0, 1'b0);
        send_item(mhit_pkg::OP_SEG, 19, C_MIN, C_MIN, C_MIN, C_MIN, 1'b0);
        send_item(mhit_pkg::OP_POINT, 20, 10, 10, 0, 0, 1'b1);

        // Random shapes under a range of settings, extremes among them.
        run_phase(near_origin(), near_origin(), near_origin(), near_origin(), 1'b0, 90);
        run_phase(near_origin(), near_origin(), near_origin(), near_origin(), 1'b1, 90);
        run_phase(C_MIN, C_MAX, C_MAX, C_MIN, 1'b0, 70);
        run_phase(C_MIN, C_MAX, C_MAX, C_MIN, 1'b1, 70);
        cx = near_origin();
        run_phase(cx, near_origin(), cx, near_origin(), 1'b1, 70);
        run_phase($urandom, $urandom, $urandom, $urandom, 1'b1, 70);
        run_phase($urandom, $urandom, $urandom, $urandom, 1'b0, 60);
        run_phase(near_origin(), near_origin(), near_origin(), near_origin(), 1'b1, 110);

        // Drain with a bound, then give the verdict.
        @(negedge clk);
        item_valid <= 1'b0;
        for (int w = 0; w < 20000 && hits_owed != 0; w++)
            @(posedge clk);
        repeat (30) @(posedge clk);
        if (hits_owed != 0)
            $display("%0d result words never arrived", hits_owed);
        if (mismatches == 0 && hits_owed == 0)
            $display("[marquee_hit_test_top] OK");
        else
            $display("[marquee_hit_test_top] ERROR");
        $finish;
    end

endmodule
